FILE: hw/rtl/status_led_pattern_generator_top_assert.svh
// ----------------------------------------------------------------------------
// Status LED pattern generator: assertion macros
// Shared concurrent assertion forms for the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_PATTERN_GENERATOR_TOP_ASSERT_SVH
`define STATUS_LED_PATTERN_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define SLPG_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// next-cycle implication
`define SLPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

FILE: hw/rtl/slpg_pkg.sv
// ----------------------------------------------------------------------------
// Status LED pattern generator package
// Request and result types, codes and arithmetic constants.
// ----------------------------------------------------------------------------
package slpg_pkg;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_SET_STATUS = 2'd1,
    OP_FRAME_NOTE = 2'd2,
    OP_INIT       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    MODE_BOOT     = 3'd0,
    MODE_NO_BRAIN = 3'd1,
    MODE_IDLE     = 3'd2,
    MODE_LIVE     = 3'd3,
    MODE_ERROR    = 3'd4
  } mode_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  status_value;
    logic [31:0] now_ms;
  } evt_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_item_t;

  // render job handed from the event front end to the color pipeline
  typedef struct packed {
    logic        is_init;
    mode_t       mode;
    logic        pop;
    logic [31:0] now_ms;
  } slpg_job_t;

  // config port
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS_CAP = '0;
  localparam logic [7:0] CAP_RESET = 8'd48;

  // timing, ms
  localparam logic [31:0] RENDER_GAP_MS = 32'd16;
  localparam logic [31:0] POP_MS        = 32'd70;

  // periods
  localparam logic [11:0] P_BOOT     = 12'd2000;
  localparam logic [11:0] P_NO_BRAIN = 12'd1500;
  localparam logic [11:0] P_LIVE     = 12'd2500;

  // coarse divisors after the power-of-two part is shifted off
  localparam logic [9:0] DIV_BLINK = 10'd75;   // 150 = 2 * 75
  localparam logic [9:0] DIV_2000  = 10'd125;  // 2000 = 16 * 125
  localparam logic [9:0] DIV_1500  = 10'd375;  // 1500 = 4 * 375
  localparam logic [9:0] DIV_2500  = 10'd625;  // 2500 = 4 * 625

  // floor(2^32 / d): quotient estimate low by at most one
  localparam logic [25:0] RCP_BLINK = 26'd57266230;
  localparam logic [25:0] RCP_2000  = 26'd34359738;
  localparam logic [25:0] RCP_1500  = 26'd11453246;
  localparam logic [25:0] RCP_2500  = 26'd6871947;

  // ceil(2^32 / P): exact for products below 2^20
  localparam logic [21:0] RCPX_2000 = 22'd2147484;
  localparam logic [21:0] RCPX_1500 = 22'd2863312;
  localparam logic [21:0] RCPX_2500 = 22'd1717987;

  // floor(v*9/20) = (v*3687) >> 13 and floor(c/3) = (c*171) >> 9 for 8-bit inputs
  localparam logic [11:0] AMBER_MUL = 12'd3687;
  localparam logic [7:0]  THIRD_MUL = 8'd171;

endpackage

FILE: hw/rtl/slpg_color.sv
// ----------------------------------------------------------------------------
// Status LED color pipeline
// Turns a render job into one RGB result over five stages and an output reg.
// ----------------------------------------------------------------------------
`include "status_led_pattern_generator_top_assert.svh"

module slpg_color (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_ready,
  input  slpg_pkg::slpg_job_t job,
  input  logic [7:0]          cap,
  output logic                rgb_valid,
  input  logic                rgb_ready,
  output slpg_pkg::rgb_item_t rgb
);
  import slpg_pkg::*;

  function automatic logic [7:0] ramp_hi(mode_t m, logic [7:0] c);
    ramp_hi = (m == MODE_BOOT) ? {1'b0, c[7:1]} : c;
  endfunction

  function automatic logic [7:0] ramp_lo(mode_t m);
    case (m)
      MODE_BOOT:     ramp_lo = 8'd2;
      MODE_NO_BRAIN: ramp_lo = 8'd3;
      MODE_IDLE:     ramp_lo = 8'd3;
      default:       ramp_lo = 8'd6;
    endcase
  endfunction

  function automatic logic [11:0] period_of(mode_t m);
    case (m)
      MODE_BOOT, MODE_IDLE: period_of = P_BOOT;
      MODE_NO_BRAIN:        period_of = P_NO_BRAIN;
      default:              period_of = P_LIVE;
    endcase
  endfunction

  function automatic logic [9:0] divisor_of(mode_t m);
    case (m)
      MODE_ERROR:           divisor_of = DIV_BLINK;
      MODE_BOOT, MODE_IDLE: divisor_of = DIV_2000;
      MODE_NO_BRAIN:        divisor_of = DIV_1500;
      default:              divisor_of = DIV_2500;
    endcase
  endfunction

  // stage valids and flow control
  logic v1, v2, v3, v4, v5;
  logic take1, take2, take3, take4, take5, take_o;

  assign take_o    = !rgb_valid || rgb_ready;
  assign take5     = !v5 || take_o;
  assign take4     = !v4 || take5;
  assign take3     = !v3 || take4;
  assign take2     = !v2 || take3;
  assign take1     = !v1 || take2;
  assign job_ready = take1;

  slpg_job_t s1_job, s2_job, s3_job, s4_job, s5_job;

  // stage 1: coarse quotient estimate of now by the mode's divisor
  logic [30:0] x1;
  logic [25:0] rcp1;
  logic [56:0] prod1;

  always_comb begin
    case (s1_job.mode)
      MODE_ERROR: begin
        x1   = s1_job.now_ms[31:1];
        rcp1 = RCP_BLINK;
      end
      MODE_BOOT, MODE_IDLE: begin
        x1   = {3'b000, s1_job.now_ms[31:4]};
        rcp1 = RCP_2000;
      end
      MODE_NO_BRAIN: begin
        x1   = {1'b0, s1_job.now_ms[31:2]};
        rcp1 = RCP_1500;
      end
      default: begin
        x1   = {1'b0, s1_job.now_ms[31:2]};
        rcp1 = RCP_2500;
      end
    endcase
  end

  assign prod1 = 57'(x1) * 57'(rcp1);

  // stage 2: back-multiply the estimate
  logic [30:0] s2_x;
  logic [24:0] s2_q;
  logic [34:0] qd2;

  assign qd2 = 35'(s2_q) * 35'(divisor_of(s2_job.mode));

  // stage 3: remainder fix-up, phase fold, span times fold
  logic [30:0] s3_x, s3_qd;
  logic        s3_qlsb;
  logic [30:0] rem_raw;
  logic [10:0] rem_lo, d3;
  logic        corr3;
  logic [10:0] rem3;
  logic [11:0] t3, p3;
  logic [12:0] tw3, x3;
  logic [7:0]  hi3, lo3, span3;
  logic [19:0] prod3;

  always_comb begin
    rem_raw = s3_x - s3_qd;
    rem_lo  = rem_raw[10:0];
    d3      = {1'b0, divisor_of(s3_job.mode)};
    corr3   = rem_lo >= d3;
    rem3    = corr3 ? rem_lo - d3 : rem_lo;
    if (s3_job.mode == MODE_BOOT || s3_job.mode == MODE_IDLE) begin
      t3 = {rem3[7:0], s3_job.now_ms[3:0]};
    end else begin
      t3 = {rem3[9:0], s3_job.now_ms[1:0]};
    end
    p3    = period_of(s3_job.mode);
    tw3   = {t3, 1'b0};
    x3    = (tw3 < {1'b0, p3}) ? tw3 : {p3 - t3, 1'b0};
    hi3   = ramp_hi(s3_job.mode, cap);
    lo3   = ramp_lo(s3_job.mode);
    span3 = (hi3 > lo3) ? hi3 - lo3 : 8'd0;
    prod3 = 20'(span3) * 20'(x3[11:0]);
  end

  // stage 4: exact divide by the period
  logic [19:0] s4_prod;
  logic        s4_odd;
  logic [21:0] rcp4;
  logic [41:0] prod4;

  always_comb begin
    case (s4_job.mode)
      MODE_BOOT, MODE_IDLE: rcp4 = RCPX_2000;
      MODE_NO_BRAIN:        rcp4 = RCPX_1500;
      default:              rcp4 = RCPX_2500;
    endcase
  end

  assign prod4 = 42'(s4_prod) * 42'(rcp4);

  // stage 5: ramp value and per-mode color
  logic [7:0]  s5_quot;
  logic        s5_odd;
  logic [7:0]  hi5, lo5, v5_val;
  logic [19:0] amber5;
  logic [15:0] third5;
  rgb_item_t   rgb_next;

  always_comb begin
    hi5      = ramp_hi(s5_job.mode, cap);
    lo5      = ramp_lo(s5_job.mode);
    v5_val   = (hi5 > lo5) ? lo5 + s5_quot : hi5;
    amber5   = 20'(v5_val) * 20'(AMBER_MUL);
    third5   = 16'(cap) * 16'(THIRD_MUL);
    rgb_next = '0;
    if (s5_job.is_init) begin
      rgb_next = '{red: 8'd1, green: 8'd1, blue: 8'd1};
    end else begin
      case (s5_job.mode)
        MODE_ERROR: begin
          rgb_next.red = s5_odd ? 8'd0 : cap;
        end
        MODE_BOOT: begin
          rgb_next = '{red: v5_val, green: v5_val, blue: v5_val};
        end
        MODE_NO_BRAIN: begin
          rgb_next.red = v5_val;
        end
        MODE_IDLE: begin
          rgb_next.red   = v5_val;
          rgb_next.green = {1'b0, amber5[19:13]};
        end
        default: begin
          if (s5_job.pop) begin
            rgb_next.green = cap;
            rgb_next.blue  = {1'b0, third5[15:9]};
          end else begin
            rgb_next.green = v5_val;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      rgb_valid <= 1'b0;
    end else begin
      if (take1) v1 <= job_valid;
      if (take2) v2 <= v1;
      if (take3) v3 <= v2;
      if (take4) v4 <= v3;
      if (take5) v5 <= v4;
      if (take_o) rgb_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (take1) begin
      s1_job <= job;
    end
    if (take2) begin
      s2_job <= s1_job;
      s2_x   <= x1;
      s2_q   <= prod1[56:32];
    end
    if (take3) begin
      s3_job  <= s2_job;
      s3_x    <= s2_x;
      s3_qd   <= qd2[30:0];
      s3_qlsb <= s2_q[0];
    end
    if (take4) begin
      s4_job  <= s3_job;
      s4_prod <= prod3;
      s4_odd  <= s3_qlsb ^ corr3;
    end
    if (take5) begin
      s5_job  <= s4_job;
      s5_quot <= prod4[39:32];
      s5_odd  <= s4_odd;
    end
    if (take_o) begin
      rgb <= rgb_next;
    end
  end

  `SLPG_ASSERT_IMPL(a_full_when_blocked, clk, rst, !job_ready, v1 && v2 && v3 && v4 && v5 && rgb_valid)
  `SLPG_ASSERT_NEXT(a_init_white, clk, rst, v5 && s5_job.is_init && take_o, rgb.red == 8'd1 && rgb.green == 8'd1 && rgb.blue == 8'd1)
  `SLPG_ASSERT_NEXT(a_error_red_only, clk, rst, v5 && !s5_job.is_init && s5_job.mode == MODE_ERROR && take_o, rgb.green == 8'd0 && rgb.blue == 8'd0)

endmodule

FILE: hw/rtl/status_led_pattern_generator_top.sv
// ----------------------------------------------------------------------------
// Status LED pattern generator, top level
// Event front end, status state, config registers and color pipeline.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                     | payload
//  --------+-----+-------------------------------+----------------------------
//  evt     | in  | evt_valid / evt_ready         | operation, status_value, now_ms
//  rgb     | out | rgb_valid / rgb_ready         | red, green, blue
//  apb     | in  | psel, penable, pwrite, pready | paddr, pwdata / prdata
//
//  One request is taken per cycle while evt_ready is high. A request that
//  renders (an unthrottled tick or an init) reaches rgb through five
//  arithmetic stages, set by the chain of reciprocal multiplies, the last one
//  loading the output register. Set status and frame note update state at the
//  accept edge; they and throttled ticks yield nothing. rst is synchronous and
//  clears all state and valids. A stalled rgb side backs up the pipeline;
//  evt_ready drops only when every stage and the output register hold a result.
// ----------------------------------------------------------------------------
`include "status_led_pattern_generator_top_assert.svh"

module status_led_pattern_generator_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              evt_valid,
  output logic                              evt_ready,
  input  slpg_pkg::evt_item_t               evt,
  output logic                              rgb_valid,
  input  logic                              rgb_ready,
  output slpg_pkg::rgb_item_t               rgb,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [slpg_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import slpg_pkg::*;

  // state
  logic [7:0]  brightness_cap;
  mode_t       current_mode, current_mode_next;
  logic [31:0] frame_time;
  logic [31:0] render_time;

  // request decode
  logic        evt_accept;
  op_t         op;
  logic [31:0] render_gap, frame_gap;
  logic        render_ok;
  logic        job_valid;
  slpg_job_t   job;

  assign evt_accept = evt_valid && evt_ready;
  assign op         = op_t'(evt.operation);

  // differences wrap modulo 2^32
  assign render_gap = evt.now_ms - render_time;
  assign frame_gap  = evt.now_ms - frame_time;
  assign render_ok  = render_gap >= RENDER_GAP_MS;

  // only init and unthrottled ticks produce a result
  assign job_valid   = evt_accept && (op == OP_INIT || (op == OP_TICK && render_ok));
  assign job.is_init = (op == OP_INIT);
  assign job.mode    = current_mode;
  assign job.pop     = frame_gap < POP_MS;
  assign job.now_ms  = evt.now_ms;

  // status update: error latches until an init, out-of-range codes are dropped
  always_comb begin
    current_mode_next = current_mode;
    if (evt_accept) begin
      case (op)
        OP_SET_STATUS: begin
          if (evt.status_value <= MODE_ERROR &&
              !(current_mode == MODE_ERROR && evt.status_value != MODE_ERROR)) begin
            current_mode_next = mode_t'(evt.status_value);
          end
        end
        OP_INIT: begin
          current_mode_next = MODE_BOOT;
        end
        default: begin
          current_mode_next = current_mode;
        end
      endcase
    end
  end

  // config port: zero-wait, one register at index 0
  logic                 cfg_write;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready    = 1'b1;
  assign cfg_idx   = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (cfg_idx == REG_BRIGHTNESS_CAP) ? {24'd0, brightness_cap} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_cap <= CAP_RESET;
      current_mode   <= MODE_BOOT;
      frame_time     <= '0;
      render_time    <= '0;
    end else begin
      current_mode <= current_mode_next;
      if (cfg_write && cfg_idx == REG_BRIGHTNESS_CAP) begin
        brightness_cap <= pwdata[7:0];
      end
      if (evt_accept && op == OP_FRAME_NOTE) begin
        frame_time <= evt.now_ms;
      end
      if (evt_accept && op == OP_TICK && render_ok) begin
        render_time <= evt.now_ms;
      end
    end
  end

  // arithmetic and output register
  slpg_color u_color (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (evt_ready),
    .job       (job),
    .cap       (brightness_cap),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready),
    .rgb       (rgb)
  );

  `SLPG_ASSERT_NEXT(a_error_latched, clk, rst, current_mode == MODE_ERROR && !(evt_accept && op == OP_INIT), current_mode == MODE_ERROR)
  `SLPG_ASSERT_NEXT(a_render_time_tracks, clk, rst, evt_accept && op == OP_TICK && render_ok, render_time == $past(evt.now_ms))
  `SLPG_ASSERT_NEXT(a_init_to_boot, clk, rst, evt_accept && op == OP_INIT, current_mode == MODE_BOOT)

endmodule
